[hdl/per_key_burst_stats_table_defines.svh]
// Assertion helpers for the burst statistics table.
`ifndef PER_KEY_BURST_STATS_TABLE_DEFINES_SVH
`define PER_KEY_BURST_STATS_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PKBST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PKBST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pkbst_pkg.sv]
package pkbst_pkg;

    localparam int KEY_W  = 32;
    localparam int CNT_W  = 32;
    localparam int DIST_W = 31;
    localparam int IDX_W  = 6;
    localparam int USED_W = 7;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 136;

    localparam logic [CNT_W-1:0] BURST_MAX = '1;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  bursts;
        logic [CNT_W-1:0]  max_touches;
        logic [DIST_W-1:0] distinct_peak;
    } entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              look;
        logic              upd;
        logic              ins;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  touches;
        logic [DIST_W-1:0] distinct;
    } cell_cmd_t;

endpackage

[hdl/pkbst_cell.sv]
// One table entry: key compare, saturating update, append from the tail.
module pkbst_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  pkbst_pkg::cell_cmd_t cmd,
    input  logic              prev_valid,
    output logic              valid,
    output logic              hit,
    output pkbst_pkg::entry_t entry
);
    import pkbst_pkg::*;

    logic   valid_reg, valid_next;
    logic   hit_reg, hit_next;
    entry_t entry_reg, entry_next;
    logic   is_tail;

    // First free cell: left neighbor in use, this one not.
    assign is_tail = prev_valid && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        entry_next = entry_reg;
        if (cmd.look)
        begin
            hit_next = valid_reg && (entry_reg.key == cmd.key);
        end
        if (cmd.upd && hit_reg)
        begin
            if (entry_reg.bursts != BURST_MAX)
            begin
                entry_next.bursts = entry_reg.bursts + CNT_W'(1);
            end
            if (cmd.touches > entry_reg.max_touches)
            begin
                entry_next.max_touches = cmd.touches;
            end
            if (cmd.distinct > entry_reg.distinct_peak)
            begin
                entry_next.distinct_peak = cmd.distinct;
            end
        end
        if (cmd.ins && is_tail)
        begin
            valid_next               = 1'b1;
            entry_next.key           = cmd.key;
            entry_next.bursts        = CNT_W'(1);
            entry_next.max_touches   = cmd.touches;
            entry_next.distinct_peak = cmd.distinct;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign hit   = hit_reg;
    assign entry = entry_reg;

endmodule

[hdl/per_key_burst_stats_table.sv]
// Each item passes a compare state (S_LOOK), then an update/readout state (S_DONE) that loads the result register.
// A new item is taken only in S_IDLE or as the current item leaves S_DONE, so items never overlap.
// Input stalls while a finished item waits for the result register to drain.
// Reset clears the in-use count, the cell valid chain and the handshake state;
// entry contents stay undefined until an entry is appended.
module per_key_burst_stats_table #(
    parameter int ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, low bit up: proc_key[31:0], touches[63:32], distinct_files[94:64],
    // read_index[100:95], zero fill[103:101]
    input  logic [pkbst_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: op (0 record, 1 read)
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, low bit up: entry_valid[0], entry_key[32:1], entry_bursts[64:33],
    // entry_max_touches[96:65], entry_distinct_peak[127:97], entries_used[134:128],
    // zero fill[135]
    output logic [pkbst_pkg::OUT_DATA_W-1:0]    m_tdata,
    // tuser: status
    output logic [1:0]                          m_tuser
);
    import pkbst_pkg::*;

    `include "per_key_burst_stats_table_defines.svh"

    // Count width holds ENTRIES itself; index compare width covers both
    // the 6-bit read index and the table size.
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int JW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int UXW = (CW > USED_W) ? CW : USED_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Captured item
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  touches_reg;
    logic [DIST_W-1:0] distinct_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [CW-1:0] used_reg, used_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;

    logic      s_fire, out_free, done_fire;
    logic      any_hit, room, do_upd, do_ins;
    cell_cmd_t cmd;

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] hit_vec;
    entry_t             cell_entry [ENTRIES];

    logic [JW-1:0]  idx_ext;
    logic           rd_ok;
    entry_t         rd_entry;
    logic [UXW-1:0] used_ext;
    logic [1:0]     status;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_fire = (state_reg == S_DONE) && out_free;
    assign s_tready  = (state_reg == S_IDLE) || done_fire;
    assign s_fire    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Cell row. Every cell sees the same command; the valid bits form a
    // thermometer, so the append target is the cell right after the last
    // one in use.
    // ------------------------------------------------------------------
    assign any_hit = |hit_vec;
    assign room    = (used_reg < CW'(ENTRIES));
    assign do_upd  = done_fire && (op_reg == OP_RECORD) && any_hit;
    assign do_ins  = done_fire && (op_reg == OP_RECORD) && !any_hit && room;

    assign cmd.look     = (state_reg == S_LOOK);
    assign cmd.upd      = do_upd;
    assign cmd.ins      = do_ins;
    assign cmd.key      = key_reg;
    assign cmd.touches  = touches_reg;
    assign cmd.distinct = distinct_reg;

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_cell
        logic prev_v;
        if (gi == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = valid_vec[gi-1];
        end
        pkbst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .prev_valid(prev_v),
            .valid     (valid_vec[gi]),
            .hit       (hit_vec[gi]),
            .entry     (cell_entry[gi])
        );
    end

    // ------------------------------------------------------------------
    // Readout: only read items at indexes below the in-use count show data.
    // ------------------------------------------------------------------
    assign idx_ext = JW'(idx_reg);
    assign rd_ok   = (op_reg == OP_READ) && (idx_ext < JW'(ENTRIES)) &&
                     (idx_ext < JW'(used_reg));

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rd_ok && (idx_ext == JW'(i)))
            begin
                rd_entry = cell_entry[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Count, status, result assembly
    // ------------------------------------------------------------------
    assign used_next = do_ins ? (used_reg + CW'(1)) : used_reg;
    assign used_ext  = UXW'(used_next);

    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            status = ST_READ;
        end
        else if (any_hit)
        begin
            status = ST_UPDATED;
        end
        else if (room)
        begin
            status = ST_INSERTED;
        end
        else
        begin
            status = ST_DROPPED;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status;
                    m_tdata_next  = {1'b0, used_ext[USED_W-1:0],
                                     rd_entry.distinct_peak, rd_entry.max_touches,
                                     rd_entry.bursts, rd_entry.key, rd_ok};
                    state_next    = s_fire ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (s_fire)
        begin
            op_reg       <= s_tuser;
            key_reg      <= s_tdata[31:0];
            touches_reg  <= s_tdata[63:32];
            distinct_reg <= s_tdata[94:64];
            idx_reg      <= s_tdata[100:95];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Keys are unique, so at most one cell can match.
    `PKBST_ASSERT_NOW(a_hit_unique, state_reg == S_DONE, $onehot0(hit_vec), "multiple key hits")
    // Valid chain and count stay in step.
    `PKBST_ASSERT_NOW(a_count_chain, 1'b1, $countones(valid_vec) == used_reg, "count/chain mismatch")
    `PKBST_ASSERT_NOW(a_count_bound, 1'b1, used_reg <= CW'(ENTRIES), "count past table size")
    // An append raises the count by exactly one.
    `PKBST_ASSERT_NEXT(a_append, do_ins, used_reg == $past(used_reg) + CW'(1), "append lost")

endmodule
